/* src/swm_pkg.sv */
`timescale 1ns / 1ps

package swm_pkg;

    // field widths
    localparam int unsigned COORD_W = 5;
    localparam int unsigned SPU_W   = 12;
    localparam int unsigned REM_W   = 17;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned COIL_W  = 4;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 16;

    // steps per unit after reset: 43 teeth times 8 half steps
    localparam logic [SPU_W-1:0] STEPS_RESET = SPU_W'(43 * 8);

    // item kinds carried in tuser
    localparam logic KIND_WAYPOINT = 1'b0;
    localparam logic KIND_TICK     = 1'b1;

    // direction codes
    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_REV = 1'b1;

    // control from the top level to one axis
    typedef struct packed {
        logic go;         // the registered item is processed this cycle
        logic tick;       // item is a step tick
        logic limits_ok;  // all limit switches closed
    } axis_ctl_t;

    // status from one axis back to the top level
    typedef struct packed {
        logic              busy;       // steps remaining before this item
        logic              busy_next;  // steps remaining after this item
        logic [COIL_W-1:0] coil_next;  // held coil pattern after this item
    } axis_stat_t;

    // 8-phase half-step coil patterns, bits in4 in3 in2 in1
    function automatic logic [COIL_W-1:0] half_step(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] pat;
        case (phase)
            3'd0:    pat = 4'h8;
            3'd1:    pat = 4'hC;
            3'd2:    pat = 4'h4;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h2;
            3'd5:    pat = 4'h3;
            3'd6:    pat = 4'h1;
            3'd7:    pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

/* src/two_axis_stepper_waypoint_mover.sv */
`timescale 1ns / 1ps

// Two-axis stepper controller with half-step coil sequencing.
// Input items on s_axis: tuser is the kind (0 waypoint, 1 step tick), tdata
// carries target_x, target_y and limits_ok. A waypoint plans a step count
// and direction per axis from the difference to the previous waypoint times
// steps_per_unit; a tick advances every axis that still has steps, or aborts
// the move when limits_ok is low.
// Every item gives one result item on m_axis: held coil patterns for x and
// y, a moving flag and an aborted flag.
// steps_per_unit is written through cfg_we / cfg_wdata; the user must write
// it only while idle (not enforced); it takes effect for the next waypoint.
// After acceptance an item waits in the input register and is processed into
// the output register, which offers the result; one item is accepted per
// cycle while m_axis does not stall, with the single processing stage between
// the input register and the output register.
// When m_axis stalls the output register holds, the input register fills,
// and s_axis_tready drops until the result is taken.
// Reset clears positions, step counts, phases, coils and the abort flag,
// and loads steps_per_unit with 344.
module two_axis_stepper_waypoint_mover
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata,      // steps_per_unit
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // target_x[4:0], target_y[9:5], limits_ok[10], zero
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // coil_x[3:0], coil_y[7:4], moving[8], aborted[9], zero
);

    logic [swm_pkg::SPU_W-1:0] spu_reg;

    // input register
    logic                               in_valid_reg;
    logic                               in_kind_reg;
    logic signed [swm_pkg::COORD_W-1:0] in_tx_reg;
    logic signed [swm_pkg::COORD_W-1:0] in_ty_reg;
    logic                               in_lim_reg;

    // output register
    logic                        out_valid_reg;
    logic [swm_pkg::COIL_W-1:0]  out_coil_x_reg;
    logic [swm_pkg::COIL_W-1:0]  out_coil_y_reg;
    logic                        out_moving_reg;
    logic                        out_aborted_reg;

    logic                abort_reg, abort_next;
    logic                advance;
    swm_pkg::axis_ctl_t  ctl;
    swm_pkg::axis_stat_t stat_x, stat_y;

    // handshake
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // steps per unit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            spu_reg <= swm_pkg::STEPS_RESET;
        else if (cfg_we)
            spu_reg <= cfg_wdata;
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg <= s_axis_tuser;
            in_tx_reg   <= s_axis_tdata[4:0];
            in_ty_reg   <= s_axis_tdata[9:5];
            in_lim_reg  <= s_axis_tdata[10];
        end
    end

    // per-axis planning and stepping
    assign ctl.go        = advance;
    assign ctl.tick      = (in_kind_reg == swm_pkg::KIND_TICK);
    assign ctl.limits_ok = in_lim_reg;

    swm_axis u_axis_x
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .target         (in_tx_reg),
        .steps_per_unit (spu_reg),
        .stat           (stat_x)
    );

    swm_axis u_axis_y
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .target         (in_ty_reg),
        .steps_per_unit (spu_reg),
        .stat           (stat_y)
    );

    // abort flag: cleared by a waypoint, set by an open limit during a move
    always_comb
    begin
        abort_next = abort_reg;
        if (advance)
        begin
            if (!ctl.tick)
                abort_next = 1'b0;
            else if (!ctl.limits_ok && (stat_x.busy || stat_y.busy))
                abort_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            abort_reg <= 1'b0;
        else
            abort_reg <= abort_next;
    end

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_coil_x_reg  <= stat_x.coil_next;
            out_coil_y_reg  <= stat_y.coil_next;
            out_moving_reg  <= stat_x.busy_next || stat_y.busy_next;
            out_aborted_reg <= abort_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_aborted_reg, out_moving_reg,
                            out_coil_y_reg, out_coil_x_reg};

`ifndef SYNTH
    // an aborted move never reports steps remaining
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_aborted_reg |-> !out_moving_reg)
        else $error("aborted result still shows moving");

    // a processed item always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item lost its result");

    // a stalled output keeps the pending input item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_axis_tready |=> in_valid_reg)
        else $error("input item dropped during stall");
`endif

endmodule

/* src/swm_axis.sv */
`timescale 1ns / 1ps

module swm_axis
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  swm_pkg::axis_ctl_t                   ctl,
    input  logic signed [swm_pkg::COORD_W-1:0]   target,
    input  logic        [swm_pkg::SPU_W-1:0]     steps_per_unit,
    output swm_pkg::axis_stat_t                  stat
);

    logic signed [swm_pkg::COORD_W-1:0] last_reg, last_next;
    logic [swm_pkg::REM_W-1:0]          remaining_reg, remaining_next;
    logic                               dir_reg, dir_next;
    logic [swm_pkg::PHASE_W-1:0]        phase_reg, phase_next;
    logic [swm_pkg::COIL_W-1:0]         coil_reg, coil_next;

    logic signed [swm_pkg::COORD_W:0]   diff;
    logic [swm_pkg::COORD_W-1:0]        mag;
    logic [swm_pkg::REM_W-1:0]          planned;
    logic                               busy;

    // waypoint planning: magnitude of the move times steps per unit
    always_comb
    begin
        diff    = {target[swm_pkg::COORD_W-1], target}
                - {last_reg[swm_pkg::COORD_W-1], last_reg};
        mag     = diff[swm_pkg::COORD_W] ? swm_pkg::COORD_W'(-diff)
                                         : swm_pkg::COORD_W'(diff);
        planned = swm_pkg::REM_W'(mag) * swm_pkg::REM_W'(steps_per_unit);
    end

    assign busy = (remaining_reg != '0);

    // next state for one item
    always_comb
    begin
        last_next      = last_reg;
        remaining_next = remaining_reg;
        dir_next       = dir_reg;
        phase_next     = phase_reg;
        coil_next      = coil_reg;
        if (ctl.go)
        begin
            if (!ctl.tick)
            begin
                last_next      = target;
                remaining_next = planned;
                dir_next       = diff[swm_pkg::COORD_W] ? swm_pkg::DIR_REV : swm_pkg::DIR_FWD;
            end
            else if (!ctl.limits_ok)
            begin
                remaining_next = '0;
            end
            else if (busy)
            begin
                coil_next      = swm_pkg::half_step(phase_reg);
                phase_next     = (dir_reg == swm_pkg::DIR_REV) ? phase_reg - 1'b1
                                                               : phase_reg + 1'b1;
                remaining_next = remaining_reg - 1'b1;
            end
        end
    end

    // axis state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= '0;
            remaining_reg <= '0;
            dir_reg       <= swm_pkg::DIR_FWD;
            phase_reg     <= '0;
            coil_reg      <= '0;
        end
        else
        begin
            last_reg      <= last_next;
            remaining_reg <= remaining_next;
            dir_reg       <= dir_next;
            phase_reg     <= phase_next;
            coil_reg      <= coil_next;
        end
    end

    assign stat.busy      = busy;
    assign stat.busy_next = (remaining_next != '0);
    assign stat.coil_next = coil_next;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

import swm_pkg::*;

// predicts the coil drive for every accepted item and checks the results
class coil_scoreboard;
    logic [SPU_W-1:0]          steps_per_unit;
    logic signed [COORD_W-1:0] last_pos [2];
    logic [REM_W-1:0]          steps_left [2];
    logic                      dir [2];
    logic [PHASE_W-1:0]        phase [2];
    logic [COIL_W-1:0]         coil [2];
    logic                      abort_flag;
    logic [OUT_DATA_W-1:0]     expected_drive [$];
    int                        errors;

    function new();
        steps_per_unit = STEPS_RESET;
        for (int a = 0; a < 2; a++)
        begin
            last_pos[a]   = '0;
            steps_left[a] = '0;
            dir[a]        = DIR_FWD;
            phase[a]      = '0;
            coil[a]       = '0;
        end
        abort_flag = 1'b0;
        errors     = 0;
    endfunction

    function void set_steps(logic [SPU_W-1:0] value);
        steps_per_unit = value;
    endfunction

    // half-step sequence, in4..in1
    function logic [COIL_W-1:0] coil_pattern(logic [PHASE_W-1:0] ph);
        case (ph)
            3'd0:    return 4'h8;
            3'd1:    return 4'hC;
            3'd2:    return 4'h4;
            3'd3:    return 4'h6;
            3'd4:    return 4'h2;
            3'd5:    return 4'h3;
            3'd6:    return 4'h1;
            default: return 4'h9;
        endcase
    endfunction

    // step count and direction from the move distance
    function void plan_axis(int a, logic signed [COORD_W-1:0] target);
        int diff;
        int mag;
        diff = int'(target) - int'(last_pos[a]);
        dir[a] = (diff < 0) ? DIR_REV : DIR_FWD;
        mag = (diff < 0) ? -diff : diff;
        steps_left[a] = REM_W'(mag * int'(steps_per_unit));
        last_pos[a] = target;
    endfunction

    // one half step on an axis that still has steps
    function void step_axis(int a);
        if (steps_left[a] == 0)
            return;
        coil[a] = coil_pattern(phase[a]);
        if (dir[a] == DIR_REV)
            phase[a] = phase[a] - 3'd1;
        else
            phase[a] = phase[a] + 3'd1;
        steps_left[a] = steps_left[a] - 1'b1;
    endfunction

    function void apply_item(logic kind, logic signed [COORD_W-1:0] tx,
                             logic signed [COORD_W-1:0] ty, logic lim);
        logic moving;
        if (kind == KIND_WAYPOINT)
        begin
            plan_axis(0, tx);
            plan_axis(1, ty);
            abort_flag = 1'b0;
        end
        else if (!lim)
        begin
            // open limit switch stops the move
            if (steps_left[0] != 0 || steps_left[1] != 0)
                abort_flag = 1'b1;
            steps_left[0] = '0;
            steps_left[1] = '0;
        end
        else
        begin
            step_axis(0);
            step_axis(1);
        end
        moving = (steps_left[0] != 0) || (steps_left[1] != 0);
        expected_drive.push_back({6'd0, abort_flag, moving, coil[1], coil[0]});
    endfunction

    function void check_drive(logic [OUT_DATA_W-1:0] act);
        logic [OUT_DATA_W-1:0] want;
        if (expected_drive.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result item %h", act);
            return;
        end
        want = expected_drive.pop_front();
        if (act[3:0] !== want[3:0] || act[7:4] !== want[7:4] || act[8] !== want[8]
            || act[9] !== want[9] || act[15:10] !== want[15:10])
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch coil_x %h/%h coil_y %h/%h moving %b/%b aborted %b/%b pad %h/%h",
                         want[3:0], act[3:0], want[7:4], act[7:4], want[8], act[8],
                         want[9], act[9], want[15:10], act[15:10]);
        end
    endfunction
endclass

module testbench;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 115;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [SPU_W-1:0]      cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic no_idle = 1'b0;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   cycles = 0;

    logic [SPU_W-1:0] phase_steps [6] = '{12'd3, 12'd1, 12'd0, 12'd4095, 12'd2, STEPS_RESET};

    coil_scoreboard sb = new();

    two_axis_stepper_waypoint_mover dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side ready: random stalls, or one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= no_idle || ($urandom_range(99) >= 13);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_drive(m_axis_tdata);
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        return COORD_W'($urandom_range(18) - 9);
    endfunction

    // offer one item and wait for it to be taken
    task automatic send_item(input logic kind, input logic signed [COORD_W-1:0] tx,
                             input logic signed [COORD_W-1:0] ty, input logic lim);
        while (!no_idle && $urandom_range(99) < 13)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'd0, lim, ty, tx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.apply_item(kind, tx, ty, lim);
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_drive.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_steps(input logic [SPU_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_steps(value);
    endtask

    // waypoints followed by runs of ticks, with some random noise items
    task automatic run_moves(input int n);
        int sent = 0;
        int ticks;
        while (sent < n)
        begin
            if ($urandom_range(99) < 10)
            begin
                send_item(logic'($urandom_range(1)), rand_coord(), rand_coord(),
                          logic'($urandom_range(1)));
                sent++;
            end
            else
            begin
                send_item(KIND_WAYPOINT, rand_coord(), rand_coord(), logic'($urandom_range(1)));
                sent++;
                ticks = $urandom_range(40);
                for (int t = 0; t < ticks && sent < n; t++)
                begin
                    send_item(KIND_TICK, COORD_W'($urandom), COORD_W'($urandom),
                              $urandom_range(99) >= 4);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset steps per unit, idle ticks, moves, waypoint while moving, aborts
        send_item(KIND_TICK, 0, 0, 1'b1);
        send_item(KIND_TICK, 0, 0, 1'b0);
        send_item(KIND_WAYPOINT, 1, -1, 1'b1);
        send_item(KIND_TICK, 0, 0, 1'b1);
        send_item(KIND_TICK, 0, 0, 1'b1);
        send_item(KIND_TICK, 0, 0, 1'b1);
        send_item(KIND_WAYPOINT, 1, -1, 1'b0);
        send_item(KIND_TICK, 0, 0, 1'b1);
        send_item(KIND_WAYPOINT, 9, 9, 1'b1);
        send_item(KIND_TICK, -16, 15, 1'b1);
        send_item(KIND_TICK, 0, 0, 1'b0);
        send_item(KIND_TICK, 0, 0, 1'b1);
        send_item(KIND_WAYPOINT, -9, -9, 1'b0);
        send_item(KIND_TICK, 0, 0, 1'b1);
        drain();

        // step size of one: short moves that run out
        write_steps(12'd1);
        send_item(KIND_WAYPOINT, -8, -9, 1'b1);
        send_item(KIND_TICK, 0, 0, 1'b1);
        send_item(KIND_TICK, 0, 0, 1'b1);
        send_item(KIND_WAYPOINT, 9, -9, 1'b1);
        send_item(KIND_TICK, 0, 0, 1'b1);
        send_item(KIND_TICK, 0, 0, 1'b1);
        send_item(KIND_TICK, 0, 0, 1'b1);
        drain();

        // largest step size: biggest step counts
        write_steps(12'd4095);
        send_item(KIND_WAYPOINT, 9, 9, 1'b1);
        send_item(KIND_TICK, 0, 0, 1'b1);
        send_item(KIND_WAYPOINT, -9, -9, 1'b1);
        send_item(KIND_TICK, 0, 0, 1'b0);
        drain();

        // random phases over several step sizes
        for (int p = 0; p < 6; p++)
        begin
            write_steps(phase_steps[p]);
            no_idle <= (p == 2);
            if (p == 3)
                hold_req <= hold_req + 1;
            run_moves(PHASE_ITEMS);
            drain();
        end

        if (sb.errors == 0 && sb.expected_drive.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
